FILE: src/pwab_pkg.sv
// Package for the perspective warp and alpha blend block.
// Holds the item and result word types, register indexes and datapath widths.
// Used by pwab_div and perspective_warp_alpha_blend.
package pwab_pkg;

  // Quotient bits kept by the divider (covers coordinates up to 1024)
  localparam int unsigned QBITS = 11;
  // Width of a numerator or denominator magnitude (Q16.16 sum of three terms)
  localparam int unsigned NUM_W = 45;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic [2:0] REG_COEF_ROW0_A        = 3'd0;
  localparam logic [2:0] REG_COEF_ROW0_B_ROW1_A = 3'd1;
  localparam logic [2:0] REG_COEF_ROW1_B        = 3'd2;
  localparam logic [2:0] REG_COEF_ROW2_A        = 3'd3;
  localparam logic [2:0] REG_COEF_ROW2_B        = 3'd4;
  localparam logic [2:0] REG_ALPHA_GAIN         = 3'd5;

  typedef struct packed {
    logic       command;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       hit;
  } out_word_t;

endpackage

FILE: src/pwab_div.sv
// Pipelined restoring divider of two unsigned magnitudes, one quotient bit per stage.
// The caller guarantees num < den << QBITS; every stage advances only while en_i is high.
// Depends on pwab_pkg for widths.
module pwab_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pwab_pkg::NUM_W-1:0]   num_i,
  input  logic [pwab_pkg::NUM_W-1:0]   den_i,
  output logic [pwab_pkg::QBITS-1:0]   quo_o
);

  localparam int unsigned QB = pwab_pkg::QBITS;
  localparam int unsigned NW = pwab_pkg::NUM_W;
  localparam int unsigned RW = NW + QB;

  logic [RW-1:0] rem_q [QB];
  logic [NW-1:0] dv_q  [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [NW-1:0] dv_in;
    logic [QB-1:0] quo_in;
    logic [RW-1:0] shifted;

    // Pick the stage input
    if (k == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign dv_in  = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dv_in  = dv_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = RW'(dv_in) << (QB - 1 - k);

    // Subtract the shifted divisor when it fits and set the quotient bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= dv_in;
        if (rem_in >= shifted) begin
          rem_q[k] <= rem_in - shifted;
          quo_q[k] <= quo_in | (QB'(1) << (QB - 1 - k));
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

FILE: src/perspective_warp_alpha_blend.sv
// Perspective warp with additive alpha blend over an internal source image store.
// Stages in order: input, products, sums, magnitudes, divider, range check, store, blend.
// Throughput: one word per cycle, but a stall on the output holds the whole pipeline.
// Loads give no result; they write the pixel store at the same stage where projects read it.
// Reset clears control state, sets m00 = 1 LSB, m12 = m22 = 1.0, the rest 0, alpha to 1.0;
// the pixel store is undefined until loaded.
module perspective_warp_alpha_blend #(
  parameter int unsigned SRC_WIDTH  = 64,
  parameter int unsigned SRC_HEIGHT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwab_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pwab_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  localparam int unsigned QB    = pwab_pkg::QBITS;
  localparam int unsigned NW    = pwab_pkg::NUM_W;
  localparam int unsigned DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [QB-1:0] WLIM = QB'(SRC_WIDTH);
  localparam logic [QB-1:0] HLIM = QB'(SRC_HEIGHT);
  localparam logic [21:0]   WMUL = 22'(SRC_WIDTH);

  typedef struct packed {
    logic                valid;
    pwab_pkg::in_word_t  word;
    logic                neg_u;
    logic                neg_v;
    logic                big_u;
    logic                big_v;
    logic                den_zero;
  } side_t;

  // Configuration registers
  logic [63:0] coef0_q, coef1_q, coef2_q, coef3_q;
  logic [31:0] m22_q;
  logic [9:0]  alpha_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef0_q <= 64'h0000_0001_0000_0000;
      coef1_q <= '0;
      coef2_q <= 64'h0000_0000_0001_0000;
      coef3_q <= '0;
      m22_q   <= 32'h0001_0000;
      alpha_q <= 10'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwab_pkg::REG_COEF_ROW0_A:        coef0_q <= cfg_data_i;
        pwab_pkg::REG_COEF_ROW0_B_ROW1_A: coef1_q <= cfg_data_i;
        pwab_pkg::REG_COEF_ROW1_B:        coef2_q <= cfg_data_i;
        pwab_pkg::REG_COEF_ROW2_A:        coef3_q <= cfg_data_i;
        pwab_pkg::REG_COEF_ROW2_B:        m22_q   <= cfg_data_i[31:0];
        pwab_pkg::REG_ALPHA_GAIN:         alpha_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Advance every stage when the output register is free or being taken
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 0: input register
  logic               v0_q;
  pwab_pkg::in_word_t w0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w0_q <= in_word_i;
    end
  end

  // Stage 1: six coefficient products
  logic signed [10:0] xs, ys;
  logic signed [42:0] p_ux_q, p_uy_q, p_vx_q, p_vy_q, p_dx_q, p_dy_q;
  logic               v1_q;
  pwab_pkg::in_word_t w1_q;

  assign xs = signed'({1'b0, w0_q.pos_x});
  assign ys = signed'({1'b0, w0_q.pos_y});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_ux_q <= signed'(coef0_q[63:32]) * xs;
      p_uy_q <= signed'(coef0_q[31:0])  * ys;
      p_vx_q <= signed'(coef1_q[31:0])  * xs;
      p_vy_q <= signed'(coef2_q[63:32]) * ys;
      p_dx_q <= signed'(coef3_q[63:32]) * xs;
      p_dy_q <= signed'(coef3_q[31:0])  * ys;
      w1_q   <= w0_q;
    end
  end

  // Stage 2: numerator and denominator sums
  logic signed [NW-1:0] nu_q, nv_q, den_q;
  logic               v2_q;
  pwab_pkg::in_word_t w2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nu_q  <= NW'(p_ux_q) + NW'(p_uy_q) + NW'(signed'(coef1_q[63:32]));
      nv_q  <= NW'(p_vx_q) + NW'(p_vy_q) + NW'(signed'(coef2_q[31:0]));
      den_q <= NW'(p_dx_q) + NW'(p_dy_q) + NW'(signed'(m22_q));
      w2_q  <= w1_q;
    end
  end

  // Stage 3: magnitudes and signs
  logic [NW-1:0]      au_q, av_q, ad_q;
  logic               neg_u_q, neg_v_q, dz_q;
  logic               v3_q;
  pwab_pkg::in_word_t w3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      au_q    <= nu_q[NW-1]  ? NW'(-nu_q)  : NW'(nu_q);
      av_q    <= nv_q[NW-1]  ? NW'(-nv_q)  : NW'(nv_q);
      ad_q    <= den_q[NW-1] ? NW'(-den_q) : NW'(den_q);
      neg_u_q <= nu_q[NW-1] ^ den_q[NW-1];
      neg_v_q <= nv_q[NW-1] ^ den_q[NW-1];
      dz_q    <= (den_q == '0);
      w3_q    <= w2_q;
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Dividers run QB stages; the side line carries the word alongside
  logic [NW+QB-1:0] den_sh;
  logic [QB-1:0]    q_u, q_v;
  side_t            side_in;
  side_t            side_q [QB];

  assign den_sh = {ad_q, QB'(0)};

  pwab_div u_div_u (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (au_q),
    .den_i (ad_q),
    .quo_o (q_u)
  );

  pwab_div u_div_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (av_q),
    .den_i (ad_q),
    .quo_o (q_v)
  );

  always_comb begin
    side_in.valid    = v3_q;
    side_in.word     = w3_q;
    side_in.neg_u    = neg_u_q;
    side_in.neg_v    = neg_v_q;
    side_in.big_u    = ((NW+QB)'(au_q) >= den_sh);
    side_in.big_v    = ((NW+QB)'(av_q) >= den_sh);
    side_in.den_zero = dz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QB; k++) begin
        side_q[k] <= '0;
      end
    end else if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < QB; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 5: range check and store address
  side_t   sd;
  logic    u_ok, v_ok, ld_ok;
  logic [21:0] proj_addr, load_addr;
  logic    v5_q, hit5_q, wr5_q;
  logic [AW-1:0] addr5_q;
  pwab_pkg::in_word_t w5_q;

  assign sd    = side_q[QB-1];
  assign u_ok  = !sd.big_u && (q_u == '0 || !sd.neg_u) && (q_u < WLIM);
  assign v_ok  = !sd.big_v && (q_v == '0 || !sd.neg_v) && (q_v < HLIM);
  assign ld_ok = (QB'(sd.word.pos_x) < WLIM) && (QB'(sd.word.pos_y) < HLIM);
  assign proj_addr = 22'(q_v) * WMUL + 22'(q_u);
  assign load_addr = 22'(sd.word.pos_y) * WMUL + 22'(sd.word.pos_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q   <= 1'b0;
      hit5_q <= 1'b0;
      wr5_q  <= 1'b0;
    end else if (adv) begin
      v5_q   <= sd.valid && (sd.word.command == pwab_pkg::CMD_PROJECT);
      hit5_q <= (sd.word.command == pwab_pkg::CMD_PROJECT) && !sd.den_zero && u_ok && v_ok;
      wr5_q  <= sd.valid && (sd.word.command == pwab_pkg::CMD_LOAD) && ld_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      addr5_q <= (sd.word.command == pwab_pkg::CMD_LOAD) ? proj_addr[AW-1:0] & '0 |
                 load_addr[AW-1:0] : proj_addr[AW-1:0];
      w5_q    <= sd.word;
    end
  end

  // Stage 6: pixel store, written by loads and read by projects in order
  logic [23:0] pix_mem [DEPTH];
  logic [23:0] rd_q;
  logic        v6_q, hit6_q;
  pwab_pkg::in_word_t w6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wr5_q) begin
        pix_mem[addr5_q] <= {w5_q.in_red, w5_q.in_green, w5_q.in_blue};
      end
      rd_q <= pix_mem[addr5_q];
      w6_q <= w5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q   <= 1'b0;
      hit6_q <= 1'b0;
    end else if (adv) begin
      v6_q   <= v5_q;
      hit6_q <= hit5_q;
    end
  end

  // Stage 7: blend and output register
  function automatic logic [7:0] blend(input logic [7:0] dst, input logic [7:0] src,
                                       input logic [9:0] gain);
    logic [17:0] prod;
    logic [10:0] sum;
    prod = 18'(src) * 18'(gain);
    sum  = 11'(dst) + 11'(prod[17:8]);
    return (sum > 11'd255) ? 8'd255 : sum[7:0];
  endfunction

  pwab_pkg::out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (hit6_q) begin
        out_word_q.out_red   <= blend(w6_q.in_red,   rd_q[23:16], alpha_q);
        out_word_q.out_green <= blend(w6_q.in_green, rd_q[15:8],  alpha_q);
        out_word_q.out_blue  <= blend(w6_q.in_blue,  rd_q[7:0],   alpha_q);
        out_word_q.hit       <= 1'b1;
      end else begin
        out_word_q.out_red   <= w6_q.in_red;
        out_word_q.out_green <= w6_q.in_green;
        out_word_q.out_blue  <= w6_q.in_blue;
        out_word_q.hit       <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: bench/tb_perspective_warp_alpha_blend.sv
// Testbench for perspective_warp_alpha_blend: loads source pixels, projects destination
// pixels under a series of homography and alpha settings, and checks every result word.
// Depends on pwab_pkg for the word types, command codes and register indexes.
module tb_perspective_warp_alpha_blend;

  localparam int unsigned SRC_W = 64;
  localparam int unsigned SRC_H = 64;
  localparam int unsigned PIPE_CYCLES = 40;

  // Warp predictor: own copy of coefficients, gain and pixel store
  class warp_scoreboard;
    logic [63:0] row0_a, row0_b_row1_a, row1_b, row2_a;
    logic [31:0] row2_b;
    logic [9:0]  gain;
    logic [23:0] pixels [SRC_W*SRC_H];
    bit          loaded [SRC_W*SRC_H];
    pwab_pkg::out_word_t pending [$];
    int          errors;

    function new();
      row0_a = 64'h0000_0001_0000_0000;
      row0_b_row1_a = '0;
      row1_b = 64'h0000_0000_0001_0000;
      row2_a = '0;
      row2_b = 32'h0001_0000;
      gain = 10'd256;
      foreach (loaded[i]) loaded[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        pwab_pkg::REG_COEF_ROW0_A:        row0_a = data;
        pwab_pkg::REG_COEF_ROW0_B_ROW1_A: row0_b_row1_a = data;
        pwab_pkg::REG_COEF_ROW1_B:        row1_b = data;
        pwab_pkg::REG_COEF_ROW2_A:        row2_a = data;
        pwab_pkg::REG_COEF_ROW2_B:        row2_b = data[31:0];
        pwab_pkg::REG_ALPHA_GAIN:         gain = data[9:0];
        default: ;
      endcase
    endfunction

    // Map a destination coordinate; return the store address, or -1 on a miss
    function int map_addr(pwab_pkg::in_word_t w);
      longint x, y, nu, nv, den, u, v;
      x = longint'(w.pos_x);
      y = longint'(w.pos_y);
      nu = longint'($signed(row0_a[63:32])) * x + longint'($signed(row0_a[31:0])) * y
         + longint'($signed(row0_b_row1_a[63:32]));
      nv = longint'($signed(row0_b_row1_a[31:0])) * x + longint'($signed(row1_b[63:32])) * y
         + longint'($signed(row1_b[31:0]));
      den = longint'($signed(row2_a[63:32])) * x + longint'($signed(row2_a[31:0])) * y
          + longint'($signed(row2_b));
      if (den == 0) return -1;
      u = nu / den;
      v = nv / den;
      if (u < 0 || u >= SRC_W || v < 0 || v >= SRC_H) return -1;
      return int'(v * SRC_W + u);
    endfunction

    function bit reads_unloaded(pwab_pkg::in_word_t w);
      int a;
      if (w.command != pwab_pkg::CMD_PROJECT) return 0;
      a = map_addr(w);
      return a >= 0 && !loaded[a];
    endfunction

    function logic [7:0] blend(logic [7:0] dst, logic [7:0] src);
      int s;
      s = int'(dst) + ((int'(src) * int'(gain)) >>> 8);
      return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    // Note an accepted input word
    function void note_input(pwab_pkg::in_word_t w);
      int a;
      pwab_pkg::out_word_t r;
      if (w.command == pwab_pkg::CMD_LOAD) begin
        if (w.pos_x < SRC_W && w.pos_y < SRC_H) begin
          a = int'(w.pos_y) * SRC_W + int'(w.pos_x);
          pixels[a] = {w.in_red, w.in_green, w.in_blue};
          loaded[a] = 1;
        end
        return;
      end
      r = '{out_red: w.in_red, out_green: w.in_green, out_blue: w.in_blue, hit: 1'b0};
      a = map_addr(w);
      if (a >= 0) begin
        r.out_red = blend(w.in_red, pixels[a][23:16]);
        r.out_green = blend(w.in_green, pixels[a][15:8]);
        r.out_blue = blend(w.in_blue, pixels[a][7:0]);
        r.hit = 1'b1;
      end
      pending.push_back(r);
    endfunction

    // Check a result word against the oldest expected one
    function void check_result(pwab_pkg::out_word_t got);
      pwab_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, actual %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.out_red !== exp_w.out_red) begin
        $display("%0t: out_red expected %h actual %h", $time, exp_w.out_red, got.out_red);
        errors++;
      end
      if (got.out_green !== exp_w.out_green) begin
        $display("%0t: out_green expected %h actual %h", $time, exp_w.out_green, got.out_green);
        errors++;
      end
      if (got.out_blue !== exp_w.out_blue) begin
        $display("%0t: out_blue expected %h actual %h", $time, exp_w.out_blue, got.out_blue);
        errors++;
      end
      if (got.hit !== exp_w.hit) begin
        $display("%0t: hit expected %b actual %b", $time, exp_w.hit, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  pwab_pkg::in_word_t  in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  pwab_pkg::out_word_t out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  warp_scoreboard sb = new();
  bit quiet = 0;
  bit hold_request = 0;

  perspective_warp_alpha_blend #(.SRC_WIDTH(SRC_W), .SRC_HEIGHT(SRC_H)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o, .out_stall_i,
    .out_word_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one word, optionally after an idle burst; never project onto an unloaded pixel
  task automatic send_word(pwab_pkg::in_word_t w);
    int gap;
    if (sb.reads_unloaded(w)) w.command = pwab_pkg::CMD_LOAD;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
  endtask

  task automatic send_fields(logic cmd, int x, int y, int r, int g, int b);
    pwab_pkg::in_word_t w;
    w = '{command: cmd, pos_x: x[9:0], pos_y: y[9:0],
          in_red: r[7:0], in_green: g[7:0], in_blue: b[7:0]};
    send_word(w);
  endtask

  task automatic send_random(int count);
    pwab_pkg::in_word_t w;
    repeat (count) begin
      w.command = ($urandom_range(0, 9) < 4) ? pwab_pkg::CMD_LOAD : pwab_pkg::CMD_PROJECT;
      w.pos_x = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 63)) : 10'($urandom);
      w.pos_y = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 63)) : 10'($urandom);
      w.in_red = 8'($urandom);
      w.in_green = 8'($urandom);
      w.in_blue = 8'($urandom);
      send_word(w);
    end
  endtask

  // Wait until every expected word has come, then let loads drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_warp(logic [31:0] m00, logic [31:0] m01, logic [31:0] m02,
                          logic [31:0] m10, logic [31:0] m11, logic [31:0] m12,
                          logic [31:0] m20, logic [31:0] m21, logic [31:0] m22,
                          logic [9:0] alpha);
    drain();
    write_reg(pwab_pkg::REG_COEF_ROW0_A, {m00, m01});
    write_reg(pwab_pkg::REG_COEF_ROW0_B_ROW1_A, {m02, m10});
    write_reg(pwab_pkg::REG_COEF_ROW1_B, {m11, m12});
    write_reg(pwab_pkg::REG_COEF_ROW2_A, {m20, m21});
    write_reg(pwab_pkg::REG_COEF_ROW2_B, {32'h0, m22});
    write_reg(pwab_pkg::REG_ALPHA_GAIN, {54'h0, alpha});
  endtask

  // Receiver: check accepted words, stall in bursts and once for a long stretch
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_word_o);
      if (hold_request) begin
        hold_request = 0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: u = 0, v = 1
    send_fields(pwab_pkg::CMD_LOAD, 5, 1, 10, 20, 30);
    send_fields(pwab_pkg::CMD_PROJECT, 5, 0, 1, 2, 3);
    send_random(30);

    // Identity with double gain; corners, ignored loads, saturation
    set_warp(32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 10'd512);
    send_fields(pwab_pkg::CMD_LOAD, 0, 0, 255, 255, 255);
    send_fields(pwab_pkg::CMD_LOAD, 63, 63, 0, 0, 0);
    send_fields(pwab_pkg::CMD_LOAD, 63, 0, 128, 1, 255);
    send_fields(pwab_pkg::CMD_LOAD, 0, 63, 7, 200, 64);
    send_fields(pwab_pkg::CMD_LOAD, 64, 0, 9, 9, 9);
    send_fields(pwab_pkg::CMD_LOAD, 1023, 1023, 9, 9, 9);
    send_fields(pwab_pkg::CMD_PROJECT, 0, 0, 0, 0, 0);
    send_fields(pwab_pkg::CMD_PROJECT, 0, 0, 255, 255, 255);
    send_fields(pwab_pkg::CMD_PROJECT, 63, 63, 255, 0, 128);
    send_fields(pwab_pkg::CMD_PROJECT, 63, 0, 1, 254, 0);
    send_fields(pwab_pkg::CMD_PROJECT, 0, 63, 100, 0, 200);
    send_fields(pwab_pkg::CMD_PROJECT, 64, 0, 1, 2, 3);
    send_fields(pwab_pkg::CMD_PROJECT, 1023, 1023, 255, 255, 255);
    send_fields(pwab_pkg::CMD_PROJECT, 0, 64, 4, 5, 6);
    send_random(60);

    // Half scale with offset; long output hold fills the pipeline
    set_warp(32'h8000, 0, 32'h2_0000, 0, 32'h8000, 32'h1_0000, 0, 0, 32'h1_0000, 10'd128);
    hold_request = 1;
    send_random(70);

    // Perspective term, gain above the nominal range
    set_warp(32'h1_0000, 32'h0800, 0, 0, 32'h1_0000, 0, 32'h0100, 32'h0080, 32'h1_0000,
             10'd1023);
    send_random(60);

    // Zero denominator everywhere, zero gain
    set_warp(0, 0, 0, 0, 0, 0, 0, 0, 0, 10'd0);
    send_random(40);

    // All-ones coefficients, most negative constant term
    set_warp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 10'd0);
    send_random(40);

    // Largest positive coefficients
    set_warp(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 10'd300);
    send_random(50);

    // Negative denominator with mirrored numerators
    set_warp(32'h1_0000, 0, 32'hFFC1_0000, 0, 32'h1_0000, 32'hFFC1_0000, 0, 0,
             32'hFFFF_0000, 10'd200);
    send_random(50);

    // Fully random coefficients
    set_warp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 10'($urandom));
    send_random(30);

    // Mirror in x, no idling on either side
    set_warp(32'hFFFF_0000, 0, 32'h3F_0000, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 10'd256);
    quiet = 1;
    send_random(80);

    drain();
    if (sb.errors == 0) $display("tb_perspective_warp_alpha_blend: done, clean");
    else $display("tb_perspective_warp_alpha_blend: done, errors");
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("tb_perspective_warp_alpha_blend: done, errors");
    $finish;
  end

endmodule
